// ===== rtl/core/abp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abp_pkg
// shared types and constants of the box bounds projector
// ----------------------------------------------------------------------------
package abp_pkg;

  localparam int DATA_W            = 32;
  localparam int CORNER_COUNT      = 8;
  localparam int CORNER_IDX_W      = 3;
  localparam int AXIS_COUNT        = 3;
  localparam int REG_COUNT         = 8;
  localparam int REG_IDX_W         = 3;
  localparam int APB_ADDR_W        = 6;
  localparam int APB_DATA_W        = 64;
  localparam int QUOT_W            = 32;
  localparam int DEFAULT_FRAC_BITS = 16;

  localparam logic [CORNER_IDX_W-1:0] LAST_CORNER = CORNER_IDX_W'(CORNER_COUNT - 1);

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // identity in Q16.16, two entries per register
  localparam logic [APB_DATA_W-1:0] MATRIX_RESET [REG_COUNT] = '{
    64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
  };

  typedef logic signed [DATA_W-1:0] coord_t;
  typedef coord_t [AXIS_COUNT-1:0] point_t;
  typedef coord_t [3:0][3:0] matrix_t;   // [row][col]

  typedef struct packed {
    logic   box_present;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } box_t;

  typedef struct packed {
    coord_t ndc_min_x;
    coord_t ndc_min_y;
    coord_t ndc_min_z;
    coord_t ndc_max_x;
    coord_t ndc_max_y;
    coord_t ndc_max_z;
    logic   no_corner_kept;
  } ndc_t;

  // sideband that travels with each corner
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic present;
  } corner_tag_t;

endpackage

// ===== rtl/core/abp_corner_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abp_corner_seq
// holds one box and issues its eight corners, one per cycle while advance is high
// ----------------------------------------------------------------------------
module abp_corner_seq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 box_valid,
  input  abp_pkg::box_t        box,
  output logic                 box_stall,
  output abp_pkg::corner_tag_t tag,
  output abp_pkg::point_t      point
);
  import abp_pkg::*;

  box_t                    box_q;
  logic                    busy;
  logic [CORNER_IDX_W-1:0] cnt;
  logic                    ready;
  logic                    take;

  assign ready     = advance && (!busy || cnt == LAST_CORNER);
  assign take      = box_valid && ready;
  assign box_stall = !ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      tag.valid <= 1'b0;
    end else if (advance) begin
      tag.valid <= busy;
      if (take) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_CORNER) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      box_q <= box;
    end
    if (advance) begin
      tag.first   <= (cnt == '0);
      tag.last    <= (cnt == LAST_CORNER);
      tag.present <= box_q.box_present;
      point[0]    <= cnt[0] ? box_q.box_max_x : box_q.box_min_x;
      point[1]    <= cnt[1] ? box_q.box_max_y : box_q.box_min_y;
      point[2]    <= cnt[2] ? box_q.box_max_z : box_q.box_min_z;
    end
  end

endmodule

// ===== rtl/core/abp_transform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abp_transform
// corner times view-projection matrix: product stage, then floor and sum
// ----------------------------------------------------------------------------
module abp_transform #(
  parameter int FRAC_BITS = abp_pkg::DEFAULT_FRAC_BITS,
  parameter int CLIP_W    = 65 - FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  abp_pkg::corner_tag_t     tag_in,
  input  abp_pkg::point_t          point,
  input  abp_pkg::matrix_t         matrix,
  output abp_pkg::corner_tag_t     tag_out,
  output logic signed [CLIP_W-1:0] clip [4]
);
  import abp_pkg::*;

  corner_tag_t        tag_p;
  logic signed [63:0] prod [3][4];
  logic signed [63:0] acc  [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p.valid   <= 1'b0;
      tag_out.valid <= 1'b0;
    end else if (advance) begin
      tag_p.valid   <= tag_in.valid;
      tag_out.valid <= tag_p.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_p.first     <= tag_in.first;
      tag_p.last      <= tag_in.last;
      tag_p.present   <= tag_in.present;
      tag_out.first   <= tag_p.first;
      tag_out.last    <= tag_p.last;
      tag_out.present <= tag_p.present;
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 4; c++) begin
          prod[k][c] <= point[k] * matrix[k][c];
        end
      end
      for (int c = 0; c < 4; c++) begin
        clip[c] <= acc[c][CLIP_W-1:0];
      end
    end
  end

  // products floored to FRAC_BITS, plus translation row
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc[c] = {{32{matrix[3][c][DATA_W-1]}}, matrix[3][c]};
      for (int k = 0; k < 3; k++) begin
        acc[c] = acc[c] + (prod[k][c] >>> FRAC_BITS);
      end
    end
  end

endmodule

// ===== rtl/core/abp_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abp_divider
// pipelined restoring divide of x, y, z by w, one quotient bit per stage
// ----------------------------------------------------------------------------
module abp_divider #(
  parameter int FRAC_BITS = abp_pkg::DEFAULT_FRAC_BITS,
  parameter int CLIP_W    = 65 - FRAC_BITS,
  parameter int DEN_W     = 64 - FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  abp_pkg::corner_tag_t     tag_in,
  input  logic signed [CLIP_W-1:0] clip [4],
  output abp_pkg::corner_tag_t     tag_out,
  output abp_pkg::coord_t          quot [3],
  output logic                     skip
);
  import abp_pkg::*;

  localparam int NSTG = QUOT_W + 1;

  corner_tag_t              tag_s  [NSTG];
  logic                     skip_s [NSTG];
  logic [DEN_W-1:0]         rem_s  [NSTG][3];
  logic [DEN_W-1:0]         den_s  [NSTG][3];
  logic [QUOT_W-1:0]        nlo_s  [NSTG][3];
  logic [QUOT_W-1:0]        q_s    [NSTG][3];
  logic                     neg_s  [NSTG][3];
  logic                     ovf_s  [NSTG][3];

  logic [CLIP_W-1:0]        mag [4];
  logic [DEN_W-1:0]         un  [4];
  logic [63:0]              num [3];

  // magnitudes and scaled numerators
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      mag[c] = clip[c][CLIP_W-1] ? -clip[c] : clip[c];
      un[c]  = mag[c][DEN_W-1:0];
    end
    for (int c = 0; c < 3; c++) begin
      num[c] = {un[c], {FRAC_BITS{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_s[0].valid <= 1'b0;
    end else if (advance) begin
      tag_s[0].valid <= tag_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_s[0].first   <= tag_in.first;
      tag_s[0].last    <= tag_in.last;
      tag_s[0].present <= tag_in.present;
      skip_s[0]        <= (clip[3] == '0);
      for (int c = 0; c < 3; c++) begin
        rem_s[0][c] <= DEN_W'(num[c][63:32]);
        den_s[0][c] <= un[3];
        nlo_s[0][c] <= num[c][31:0];
        q_s[0][c]   <= '0;
        neg_s[0][c] <= clip[c][CLIP_W-1] ^ clip[3][CLIP_W-1];
        ovf_s[0][c] <= (DEN_W'(num[c][63:32]) >= un[3]);
      end
    end
  end

  for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
    logic [DEN_W:0]   trial [3];
    logic             fits  [3];

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        trial[c] = {rem_s[s][c], nlo_s[s][c][QUOT_W-1]};
        fits[c]  = (trial[c] >= {1'b0, den_s[s][c]});
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_s[s+1].valid <= 1'b0;
      end else if (advance) begin
        tag_s[s+1].valid <= tag_s[s].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        tag_s[s+1].first   <= tag_s[s].first;
        tag_s[s+1].last    <= tag_s[s].last;
        tag_s[s+1].present <= tag_s[s].present;
        skip_s[s+1]        <= skip_s[s];
        for (int c = 0; c < 3; c++) begin
          rem_s[s+1][c] <= fits[c] ? DEN_W'(trial[c] - {1'b0, den_s[s][c]})
                                   : trial[c][DEN_W-1:0];
          den_s[s+1][c] <= den_s[s][c];
          nlo_s[s+1][c] <= {nlo_s[s][c][QUOT_W-2:0], 1'b0};
          q_s[s+1][c]   <= {q_s[s][c][QUOT_W-2:0], fits[c]};
          neg_s[s+1][c] <= neg_s[s][c];
          ovf_s[s+1][c] <= ovf_s[s][c];
        end
      end
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out.valid <= 1'b0;
    end else if (advance) begin
      tag_out.valid <= tag_s[QUOT_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_out.first   <= tag_s[QUOT_W].first;
      tag_out.last    <= tag_s[QUOT_W].last;
      tag_out.present <= tag_s[QUOT_W].present;
      skip            <= skip_s[QUOT_W];
      for (int c = 0; c < 3; c++) begin
        if (neg_s[QUOT_W][c]) begin
          if (ovf_s[QUOT_W][c] || q_s[QUOT_W][c] > SAT_MIN) begin
            quot[c] <= SAT_MIN;
          end else begin
            quot[c] <= -q_s[QUOT_W][c];
          end
        end else begin
          if (ovf_s[QUOT_W][c] || q_s[QUOT_W][c][QUOT_W-1]) begin
            quot[c] <= SAT_MAX;
          end else begin
            quot[c] <= q_s[QUOT_W][c];
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/abp_bounds_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abp_bounds_acc
// folds corner quotients into min and max, holds the result register
// ----------------------------------------------------------------------------
module abp_bounds_acc (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  abp_pkg::corner_tag_t tag,
  input  abp_pkg::coord_t      quot [3],
  input  logic                 skip,
  output logic                 ndc_valid,
  output abp_pkg::ndc_t        ndc
);
  import abp_pkg::*;

  coord_t mn [3];
  coord_t mx [3];
  logic   kept;
  coord_t mn_next [3];
  coord_t mx_next [3];
  logic   kept_next;

  always_comb begin
    kept_next = (tag.first ? 1'b0 : kept) || !skip;
    for (int c = 0; c < 3; c++) begin
      mn_next[c] = tag.first ? coord_t'(SAT_MAX) : mn[c];
      mx_next[c] = tag.first ? coord_t'(SAT_MIN) : mx[c];
      if (!skip) begin
        if (quot[c] < mn_next[c]) mn_next[c] = quot[c];
        if (quot[c] > mx_next[c]) mx_next[c] = quot[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ndc_valid <= 1'b0;
    end else if (advance) begin
      ndc_valid <= tag.valid && tag.last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tag.valid) begin
      kept <= kept_next;
      for (int c = 0; c < 3; c++) begin
        mn[c] <= mn_next[c];
        mx[c] <= mx_next[c];
      end
      if (tag.last) begin
        if (tag.present) begin
          ndc.ndc_min_x      <= mn_next[0];
          ndc.ndc_min_y      <= mn_next[1];
          ndc.ndc_min_z      <= mn_next[2];
          ndc.ndc_max_x      <= mx_next[0];
          ndc.ndc_max_y      <= mx_next[1];
          ndc.ndc_max_z      <= mx_next[2];
          ndc.no_corner_kept <= !kept_next;
        end else begin
          ndc <= '0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/aabb_ndc_bounds_projector_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_ndc_bounds_projector_unit
// projects a world-space box through a 4x4 matrix, gives ndc min and max
// ----------------------------------------------------------------------------
//  channel  | ports                                   | moves
//  ---------+-----------------------------------------+-------------------------
//  box      | box_valid, box_stall, box               | one box per transfer
//  ndc      | ndc_valid, ndc_stall, ndc               | one bounds result
//  config   | psel, penable, pwrite, paddr, pwdata,   | matrix registers,
//           | prdata, pready                          | 64 bit, at 8*i
//
// the corner sequencer issues one corner per cycle while the pipeline moves,
// into a shared transform and divide pipeline, so boxes go in back to back
// each of the 8 corners passes the sequencer output, 2 transform stages, 1 divide prep,
// 32 divide stages (one quotient bit each), saturation, result register
// reset (rst, synchronous) empties the pipeline and loads the identity matrix
// a stalled result freezes the whole pipeline; nothing is dropped or repeated
// ----------------------------------------------------------------------------
module aabb_ndc_bounds_projector_unit #(
  parameter int FRAC_BITS = abp_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            box_valid,
  output logic                            box_stall,
  input  abp_pkg::box_t                   box,
  output logic                            ndc_valid,
  input  logic                            ndc_stall,
  output abp_pkg::ndc_t                   ndc,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [abp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [abp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [abp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import abp_pkg::*;

  localparam int CLIP_W = 65 - FRAC_BITS;
  localparam int DEN_W  = 64 - FRAC_BITS;

  logic [APB_DATA_W-1:0]     mreg [REG_COUNT];
  matrix_t                   matrix;
  logic [REG_IDX_W-1:0]      reg_idx;
  logic                      advance;

  corner_tag_t               tag_seq;
  point_t                    point;
  corner_tag_t               tag_xf;
  logic signed [CLIP_W-1:0]  clip [4];
  corner_tag_t               tag_div;
  coord_t                    quot [3];
  logic                      skip;

  // whole pipeline moves unless a finished result is held back
  assign advance = !(ndc_valid && ndc_stall);

  // config port, double word registers
  assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
  assign pready  = 1'b1;
  assign prdata  = mreg[reg_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        mreg[i] <= MATRIX_RESET[i];
      end
    end else if (psel && penable && pwrite && pready) begin
      mreg[reg_idx] <= pwdata;
    end
  end

  // unpack: even register holds cols 0/1, odd holds cols 2/3
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        matrix[r][c] = mreg[2*r + c/2][32*(c%2) +: 32];
      end
    end
  end

  abp_corner_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .box_valid (box_valid),
    .box       (box),
    .box_stall (box_stall),
    .tag       (tag_seq),
    .point     (point)
  );

  abp_transform #(
    .FRAC_BITS (FRAC_BITS),
    .CLIP_W    (CLIP_W)
  ) u_xf (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tag_in  (tag_seq),
    .point   (point),
    .matrix  (matrix),
    .tag_out (tag_xf),
    .clip    (clip)
  );

  abp_divider #(
    .FRAC_BITS (FRAC_BITS),
    .CLIP_W    (CLIP_W),
    .DEN_W     (DEN_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tag_in  (tag_xf),
    .clip    (clip),
    .tag_out (tag_div),
    .quot    (quot),
    .skip    (skip)
  );

  abp_bounds_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .tag       (tag_div),
    .quot      (quot),
    .skip      (skip),
    .ndc_valid (ndc_valid),
    .ndc       (ndc)
  );

  // a box is only taken while the pipeline moves
  a_take_moves: assert property (@(posedge clk) disable iff (rst)
    !box_stall |-> !(ndc_valid && ndc_stall))
    else $error("box taken while pipeline frozen");

  // all corners skipped leaves the seeds in place
  a_seeds: assert property (@(posedge clk) disable iff (rst)
    ndc_valid && ndc.no_corner_kept |->
      ndc.ndc_min_x == SAT_MAX && ndc.ndc_max_x == SAT_MIN)
    else $error("skipped box lost its seeds");

  // with a kept corner the bounds are ordered
  a_ordered: assert property (@(posedge clk) disable iff (rst)
    ndc_valid && !ndc.no_corner_kept |->
      ndc.ndc_min_x <= ndc.ndc_max_x && ndc.ndc_min_y <= ndc.ndc_max_y &&
      ndc.ndc_min_z <= ndc.ndc_max_z)
    else $error("min above max");

endmodule

// ===== sim/aabb_ndc_bounds_projector_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_ndc_bounds_projector_unit_tb
// self-checking bench for the box to ndc bounds projector: directed boxes,
// then random boxes under several matrix settings, predicted in-bench and
// compared field by field against each ndc transfer
// ----------------------------------------------------------------------------
module aabb_ndc_bounds_projector_unit_tb;
  import abp_pkg::*;

  // bounds predictor and store of expected bounds
  class ndc_scoreboard;
    logic [APB_DATA_W-1:0] mtx [REG_COUNT];
    ndc_t pending_bounds [$];
    int   err_cnt;

    function new();
      for (int i = 0; i < REG_COUNT; i++) mtx[i] = MATRIX_RESET[i];
      err_cnt = 0;
    endfunction

    function longint entry(int row, int col);
      logic [APB_DATA_W-1:0] r;
      logic signed [31:0] e;
      r = mtx[row * 2 + col / 2];
      e = (col % 2) ? r[63:32] : r[31:0];
      return longint'(e);
    endfunction

    // saturated q16.16 quotient, truncated toward zero
    function logic [31:0] quot_sat(longint num, longint den);
      logic [127:0] un, ud, q;
      bit neg;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? 128'(-num) : 128'(num);
      ud = (den < 0) ? 128'(-den) : 128'(den);
      q = (un << DEFAULT_FRAC_BITS) / ud;
      if (neg) return (q > 128'h8000_0000) ? SAT_MIN : 32'(-q);
      return (q > 128'h7FFF_FFFF) ? SAT_MAX : 32'(q);
    endfunction

    function void note_box(box_t b);
      ndc_t r;
      longint lo [3], hi [3], p [3], clip [4], mn [3], mx [3], q;
      bit kept;
      r = '0;
      if (b.box_present) begin
        lo[0] = longint'(b.box_min_x);
        lo[1] = longint'(b.box_min_y);
        lo[2] = longint'(b.box_min_z);
        hi[0] = longint'(b.box_max_x);
        hi[1] = longint'(b.box_max_y);
        hi[2] = longint'(b.box_max_z);
        kept = 0;
        for (int c = 0; c < 3; c++) begin
          mn[c] = 64'sh7FFF_FFFF; mx[c] = -64'sh8000_0000;
        end
        for (int j = 0; j < CORNER_COUNT; j++) begin
          for (int c = 0; c < 3; c++) p[c] = ((j >> c) & 1) ? hi[c] : lo[c];
          for (int c = 0; c < 4; c++) begin
            clip[c] = entry(3, c);
            // arithmetic shift floors toward minus infinity
            for (int k = 0; k < 3; k++)
              clip[c] += (p[k] * entry(k, c)) >>> DEFAULT_FRAC_BITS;
          end
          if (clip[3] != 0) begin
            kept = 1;
            for (int c = 0; c < 3; c++) begin
              q = longint'($signed(quot_sat(clip[c], clip[3])));
              if (q < mn[c]) mn[c] = q;
              if (q > mx[c]) mx[c] = q;
            end
          end
        end
        r.ndc_min_x = 32'(mn[0]); r.ndc_min_y = 32'(mn[1]); r.ndc_min_z = 32'(mn[2]);
        r.ndc_max_x = 32'(mx[0]); r.ndc_max_y = 32'(mx[1]); r.ndc_max_z = 32'(mx[2]);
        r.no_corner_kept = !kept;
      end
      pending_bounds.push_back(r);
    endfunction

    function void check_bounds(ndc_t got);
      ndc_t exp_b;
      if (pending_bounds.size() == 0) begin
        $display("%0t unexpected ndc transfer %h", $time, got);
        err_cnt++;
        return;
      end
      exp_b = pending_bounds.pop_front();
      if (got.ndc_min_x !== exp_b.ndc_min_x || got.ndc_min_y !== exp_b.ndc_min_y ||
          got.ndc_min_z !== exp_b.ndc_min_z || got.ndc_max_x !== exp_b.ndc_max_x ||
          got.ndc_max_y !== exp_b.ndc_max_y || got.ndc_max_z !== exp_b.ndc_max_z ||
          got.no_corner_kept !== exp_b.no_corner_kept) begin
        $display("%0t mismatch expected %h actual %h", $time, exp_b, got);
        err_cnt++;
      end
    endfunction
  endclass

  localparam logic [31:0] ONE = 32'h0001_0000;

  logic clk = 0;
  logic rst = 1;
  logic box_valid = 0;
  logic box_stall;
  box_t box = '0;
  logic ndc_valid;
  logic ndc_stall = 0;
  ndc_t ndc;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  ndc_scoreboard sb = new();

  // idle percentages per side, and a long hold-off request
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 0;

  always #2 clk = ~clk;

  aabb_ndc_bounds_projector_unit dut (.*);

  // result side: check each ndc transfer at the rising edge
  always @(posedge clk) begin
    if (!rst && ndc_valid && !ndc_stall) sb.check_bounds(ndc);
  end

  // receiver stall pattern, with a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        ndc_stall <= 1;
        for (int i = 0; i < 400; i++) @(negedge clk);
        hold_req = 0;
      end
      ndc_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_reg(int idx, logic [63:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= APB_ADDR_W'(idx * 8); pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.mtx[idx] = val;
  endtask

  // offer one box, hold until the transfer; valid stays up for the next box
  task automatic send_box(box_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      box_valid <= 0;
      @(negedge clk);
    end
    box <= b;
    box_valid <= 1;
    @(posedge clk);
    while (box_stall) @(posedge clk);
    sb.note_box(b);
    @(negedge clk);
  endtask

  // stop offering, wait for every expected bounds, then the pipeline depth
  task automatic drain();
    box_valid <= 0;
    while (sb.pending_bounds.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(1) ? SAT_MAX : SAT_MIN;
      default: return 32'($signed($urandom_range(2 * 655360)) - 655360);
    endcase
  endfunction

  function automatic box_t rand_box();
    box_t b;
    b.box_present = ($urandom_range(15) != 0);
    b.box_min_x = rand_coord(); b.box_min_y = rand_coord(); b.box_min_z = rand_coord();
    b.box_max_x = rand_coord(); b.box_max_y = rand_coord(); b.box_max_z = rand_coord();
    return b;
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(4 * 65536)) - 2 * 65536);
      default: return 32'($signed($urandom_range(16)) - 8) <<< 14;
    endcase
  endfunction

  task automatic random_matrix(bit w_zero);
    for (int i = 0; i < REG_COUNT; i++)
      // w column may be forced to zero so every corner gets skipped
      write_reg(i, {((w_zero && i % 2) ? 32'h0 : rand_entry()), rand_entry()});
  endtask

  initial begin
    box_t b;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed boxes under the identity matrix
    b = '0;
    send_box(b);                                   // absent box gives zeros
    b.box_present = 1;
    b.box_min_x = -ONE; b.box_min_y = -ONE; b.box_min_z = -ONE;
    b.box_max_x = ONE;  b.box_max_y = ONE;  b.box_max_z = ONE;
    send_box(b);
    b.box_min_x = SAT_MAX; b.box_max_x = SAT_MIN;  // inverted box, field extremes
    b.box_min_y = SAT_MIN; b.box_max_y = SAT_MAX;
    b.box_min_z = '1;      b.box_max_z = '0;
    send_box(b);
    b = '1;
    send_box(b);
    drain();

    // w column zero: every corner skipped
    write_reg(1, 64'h0);
    write_reg(3, 64'h0);
    write_reg(5, {32'h0, ONE});
    write_reg(7, {32'h0, 32'h0});
    b.box_present = 1;
    send_box(b);
    b = '0; b.box_present = 1;
    send_box(b);
    drain();

    // tiny w with large x: quotients saturate both ways
    write_reg(0, {32'h0, 32'h7FFF_FFFF});
    write_reg(1, {32'h0, 32'h0});
    write_reg(6, {32'h0, 32'h0});
    write_reg(7, {32'h0000_0001, 32'h0});
    b = '0; b.box_present = 1;
    b.box_min_x = SAT_MIN; b.box_max_x = SAT_MAX;
    send_box(b);
    drain();
    write_reg(7, {32'hFFFF_FFFF, 32'h0});
    send_box(b);
    drain();

    // extreme register values
    for (int i = 0; i < REG_COUNT; i++) write_reg(i, '1);
    send_box(rand_box());
    drain();
    for (int i = 0; i < REG_COUNT; i++) write_reg(i, {SAT_MIN, SAT_MAX});
    send_box(rand_box());
    send_box(rand_box());
    drain();

    // random phases: idle mixes rotate, matrix changes between phases
    for (int ph = 0; ph < 11; ph++) begin
      random_matrix(ph == 4);
      case (ph % 3)
        0: begin send_idle_pct = 14; recv_idle_pct = 52; end
        1: begin send_idle_pct = 52; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 150; n++) send_box(rand_box());
      drain();
    end

    if (sb.err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/abp_pkg.sv
rtl/core/abp_corner_seq.sv
rtl/core/abp_transform.sv
rtl/core/abp_divider.sv
rtl/core/abp_bounds_acc.sv
rtl/core/aabb_ndc_bounds_projector_unit.sv
sim/aabb_ndc_bounds_projector_unit_tb.sv
